// ----- rtl/imaenc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imaenc_pkg
// Shared types, constants and tables of the IMA/DVI ADPCM block encoder.
// ----------------------------------------------------------------------------
package imaenc_pkg;

   // Channel geometry
   localparam int NUM_LANES  = 2;
   localparam int SAMPLE_W   = 16;
   localparam int IN_W       = NUM_LANES * SAMPLE_W;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int LINE_W     = NUM_LANES * WORD_W;
   localparam int CNT_W      = 4;
   localparam int IDX_W      = 7;
   localparam int STEP_W     = 15;
   localparam int IDX_MAX    = 88;

   // Configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEREO      = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_BYTES = 1'b1;
   localparam logic [CSR_DATA_W-1:0] BLOCK_BYTES_RST = 14'd1024;

   // Block length limits
   localparam int MAX_BLOCK_DEF = 8192;
   localparam int MIN_LEN       = 64;

   localparam logic [STEP_W-1:0] STEP_TABLE [0:IDX_MAX] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // Step index adjustment by code magnitude (sign bit does not matter)
   function automatic logic signed [4:0] idx_delta(input logic [2:0] mag);
      logic signed [4:0] d;
      case (mag)
         3'd4:    d = 5'sd2;
         3'd5:    d = 5'sd4;
         3'd6:    d = 5'sd6;
         3'd7:    d = 5'sd8;
         default: d = -5'sd1;
      endcase
      return d;
   endfunction

   // Per-lane control that travels with a sample
   typedef struct packed {
      logic       hdr;
      logic       active;
      logic [2:0] frame;
   } lane_ctl_type;

   // One burst of result bytes waiting in the merge stage
   typedef struct packed {
      logic [LINE_W-1:0] data;
      logic [CNT_W-1:0]  cnt;
      logic              eob;
   } line_type;

   // Control pipeline entry in the top level
   typedef struct packed {
      logic       valid;
      logic       hdr;
      logic       emit;
      logic       eob;
      logic       stereo;
      logic [2:0] frame;
   } pipe_type;

endpackage

// ----- rtl/ima_adpcm_block_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_block_encoder
// IMA/DVI 4-bit ADPCM block encoder, one PCM frame per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one frame: left sample in req_tdata[15:0], right sample in
//          req_tdata[31:16] (ignored in mono).
//   rsp_*  carries encoded block bytes, one per transaction. rsp_tlast marks
//          the final byte caused by a frame, rsp_tuser the final byte of a block.
//   csr_*  writes stereo (index 0) and block_bytes (index 1); write only while
//          the block is idle.
// A header frame yields 4 bytes per channel; every eighth later frame yields
// 4 packed-nibble bytes per channel; other frames yield nothing.
// The block takes no new frame while the last one is in lane stage A, as the
// two-stage quantizer lane feeds its predictor back into the next frame. The
// first byte of a burst passes the input register, lane stages A and B and
// the merge stage. The merge stage holds two bursts; a frame that emits
// bytes is held off while two bursts are pending, so a stalled receiver
// backs up to req_tready. Frames that emit nothing keep flowing.
// Reset (synchronous) clears predictors, step indexes, block position, queued
// bursts, and restores mono with a 1024-byte block.
// ----------------------------------------------------------------------------
module ima_adpcm_block_encoder #(
   parameter int MAX_BLOCK = imaenc_pkg::MAX_BLOCK_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // frame in: [15:0] sample_left, [31:16] sample_right
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [imaenc_pkg::IN_W-1:0]         req_tdata,
   // byte out: [7:0] out_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [imaenc_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast,
   // [0] end_of_block
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [imaenc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [imaenc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import imaenc_pkg::*;

   localparam int BP_W    = $clog2(MAX_BLOCK);
   localparam int LEN_W   = BP_W + 1;
   localparam int MAX_LEN = (MAX_BLOCK / 8) * 8;

   // configuration registers
   logic                  stereo_ff;
   logic [CSR_DATA_W-1:0] bbytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         bbytes_ff <= BLOCK_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEREO:      stereo_ff <= csr_wdata[0];
            CSR_BLOCK_BYTES: bbytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // block length: clear low bits, saturate to the legal range
   logic [CSR_DATA_W-1:0] len_full;
   logic [LEN_W-1:0]      blk_len;

   always_comb begin
      len_full = {bbytes_ff[CSR_DATA_W-1:3], 3'b000};
      if (len_full > CSR_DATA_W'(MAX_LEN)) begin
         len_full = CSR_DATA_W'(MAX_LEN);
      end
      if (len_full < CSR_DATA_W'(MIN_LEN)) begin
         len_full = CSR_DATA_W'(MIN_LEN);
      end
      blk_len = len_full[LEN_W-1:0];
   end

   // frame control: decided at accept, independent of sample data
   logic [BP_W-1:0] bp_ff, bp_in;
   logic [2:0]      fic_ff, fic_in;
   logic [1:0]      pend_ff, pend_in;
   pipe_type        s1_ff, s2_ff, s3_ff, s1_in;
   logic [IN_W-1:0] samp_ff;
   logic            hdr_now, emit_now, acc, drain;
   logic [LEN_W-1:0] bp_sum;

   assign hdr_now  = (bp_ff == '0);
   assign emit_now = hdr_now || (fic_ff == 3'd7);
   // no frame while the last is in s1; hold emitting frames while two bursts pend
   assign req_tready = !s1_ff.valid && (!emit_now || pend_ff != 2'd2);
   assign acc   = req_tvalid && req_tready;
   assign drain = rsp_tvalid && rsp_tready && rsp_tlast;

   always_comb begin
      bp_sum       = {1'b0, bp_ff} + (stereo_ff ? LEN_W'(8) : LEN_W'(4));
      s1_in.valid  = acc;
      s1_in.hdr    = hdr_now;
      s1_in.emit   = emit_now;
      s1_in.eob    = emit_now && (bp_sum >= blk_len);
      s1_in.stereo = stereo_ff;
      s1_in.frame  = fic_ff;

      bp_in  = bp_ff;
      fic_in = fic_ff;
      if (acc) begin
         fic_in = hdr_now ? 3'd0 : fic_ff + 3'd1;
         if (emit_now) begin
            bp_in = s1_in.eob ? '0 : bp_sum[BP_W-1:0];
         end
      end

      pend_in = pend_ff;
      if (acc && emit_now && !drain) begin
         pend_in = pend_ff + 2'd1;
      end else if (drain && !(acc && emit_now)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff       <= '0;
         fic_ff      <= '0;
         pend_ff     <= '0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         bp_ff       <= bp_in;
         fic_ff      <= fic_in;
         pend_ff     <= pend_in;
         s1_ff.valid <= s1_in.valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
      end
      {s1_ff.hdr, s1_ff.emit, s1_ff.eob, s1_ff.stereo, s1_ff.frame} <=
         {s1_in.hdr, s1_in.emit, s1_in.eob, s1_in.stereo, s1_in.frame};
      {s2_ff.hdr, s2_ff.emit, s2_ff.eob, s2_ff.stereo, s2_ff.frame} <=
         {s1_ff.hdr, s1_ff.emit, s1_ff.eob, s1_ff.stereo, s1_ff.frame};
      {s3_ff.hdr, s3_ff.emit, s3_ff.eob, s3_ff.stereo, s3_ff.frame} <=
         {s2_ff.hdr, s2_ff.emit, s2_ff.eob, s2_ff.stereo, s2_ff.frame};
      if (acc) begin
         samp_ff <= req_tdata;
      end
   end

   // one quantizer lane per channel
   logic [WORD_W-1:0] lane_word [NUM_LANES];

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      lane_ctl_type lctl;
      always_comb begin
         lctl.hdr    = s1_ff.hdr;
         lctl.active = (c == 0) || s1_ff.stereo;
         lctl.frame  = s1_ff.frame;
      end
      imaenc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (s1_ff.valid),
         .sample ($signed(samp_ff[c*SAMPLE_W +: SAMPLE_W])),
         .ctl    (lctl),
         .word   (lane_word[c])
      );
   end

   // byte bursts out, channel 0 first, low byte first
   imaenc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (s3_ff.valid && s3_ff.emit),
      .stereo     (s3_ff.stereo),
      .eob        (s3_ff.eob),
      .word0      (lane_word[0]),
      .word1      (lane_word[1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/imaenc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imaenc_lane
// One channel: header capture or 4-bit IMA quantizer with predictor state.
// ----------------------------------------------------------------------------
module imaenc_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [imaenc_pkg::SAMPLE_W-1:0] sample,
   input  imaenc_pkg::lane_ctl_type             ctl,
   output logic [imaenc_pkg::WORD_W-1:0]        word
);
   import imaenc_pkg::*;

   // channel state
   logic signed [SAMPLE_W-1:0] pred_ff, pred_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [WORD_W-1:0]          word_ff, word_in;

   // stage A -> stage B
   logic                       v_ff;
   lane_ctl_type               ctl_ff;
   logic signed [SAMPLE_W-1:0] samp_ff;
   logic [SAMPLE_W-1:0]        mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [IDX_W-1:0]           idxc_ff, idxc_in;

   // stage A: difference, magnitude, step lookup
   always_comb begin
      logic signed [SAMPLE_W:0] diff;
      logic [SAMPLE_W:0]        absd;
      idxc_in = (idx_ff > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : idx_ff;
      step_in = STEP_TABLE[idxc_in];
      diff    = {sample[SAMPLE_W-1], sample} - {pred_ff[SAMPLE_W-1], pred_ff};
      neg_in  = diff[SAMPLE_W];
      absd    = neg_in ? (~diff + 1'b1) : diff;
      mag_in  = absd[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= start;
      end
      ctl_ff  <= ctl;
      samp_ff <= sample;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      idxc_ff <= idxc_in;
   end

   // stage B: successive approximation, predictor and index update
   always_comb begin
      logic [SAMPLE_W:0]        d0, d1, d2;
      logic [SAMPLE_W:0]        s0, s1, s2;
      logic [SAMPLE_W:0]        vp;
      logic                     b2, b1, b0;
      logic [3:0]               code;
      logic signed [SAMPLE_W+1:0] np, dv;
      logic signed [IDX_W:0]    ni;

      s0 = {2'b00, step_ff};
      s1 = s0 >> 1;
      s2 = s0 >> 2;
      vp = s0 >> 3;
      d0 = {1'b0, mag_ff};
      b2 = (d0 >= s0);
      d1 = b2 ? d0 - s0 : d0;
      vp = b2 ? vp + s0 : vp;
      b1 = (d1 >= s1);
      d2 = b1 ? d1 - s1 : d1;
      vp = b1 ? vp + s1 : vp;
      b0 = (d2 >= s2);
      vp = b0 ? vp + s2 : vp;
      code = {neg_ff, b2, b1, b0};

      dv = $signed({1'b0, vp});
      np = $signed({{2{pred_ff[SAMPLE_W-1]}}, pred_ff}) + (neg_ff ? -dv : dv);
      ni = $signed({1'b0, idxc_ff}) + IDX_W'(signed'(idx_delta(code[2:0])));

      pred_in = pred_ff;
      idx_in  = idx_ff;
      word_in = word_ff;
      if (v_ff) begin
         if (ctl_ff.hdr) begin
            if (ctl_ff.active) begin
               pred_in = samp_ff;
               word_in = {8'h00, 1'b0, idx_ff, samp_ff};
            end
         end else begin
            if (ctl_ff.active) begin
               if (np > 18'sd32767) begin
                  pred_in = 16'sh7FFF;
               end else if (np < -18'sd32768) begin
                  pred_in = -16'sh8000;
               end else begin
                  pred_in = np[SAMPLE_W-1:0];
               end
               if (ni < 0) begin
                  idx_in = '0;
               end else if (ni > (IDX_W+1)'(IDX_MAX)) begin
                  idx_in = IDX_W'(IDX_MAX);
               end else begin
                  idx_in = ni[IDX_W-1:0];
               end
            end
            // clear the nibble store at the first frame of a chunk
            if (ctl_ff.frame == 3'd0) begin
               word_in = ctl_ff.active ? {28'd0, code} : '0;
            end else if (ctl_ff.active) begin
               word_in = word_ff | ({28'd0, code} << {ctl_ff.frame, 2'b00});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff <= '0;
         idx_ff  <= '0;
      end else begin
         pred_ff <= pred_in;
         idx_ff  <= idx_in;
      end
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ----- rtl/imaenc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imaenc_merge
// Combine lane words into byte bursts and drain them one byte per transaction.
// ----------------------------------------------------------------------------
module imaenc_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic                                stereo,
   input  logic                                eob,
   input  logic [imaenc_pkg::WORD_W-1:0]       word0,
   input  logic [imaenc_pkg::WORD_W-1:0]       word1,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [imaenc_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);
   import imaenc_pkg::*;

   line_type a_ff, a_in;
   line_type b_ff, b_in;
   line_type fresh;
   logic     a_valid, b_valid, pop, a_free;

   always_comb begin
      fresh.data = stereo ? {word1, word0} : {{WORD_W{1'b0}}, word0};
      fresh.cnt  = stereo ? CNT_W'(2 * WORD_W / BYTE_W) : CNT_W'(WORD_W / BYTE_W);
      fresh.eob  = eob;
   end

   assign a_valid = (a_ff.cnt != '0);
   assign b_valid = (b_ff.cnt != '0);
   assign pop     = a_valid && rsp_tready;
   assign a_free  = !a_valid || (pop && a_ff.cnt == CNT_W'(1));

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (a_free) begin
         if (b_valid) begin
            a_in = b_ff;
            b_in = load ? fresh : '0;
         end else begin
            a_in = load ? fresh : '0;
         end
      end else begin
         if (pop) begin
            a_in.data = a_ff.data >> BYTE_W;
            a_in.cnt  = a_ff.cnt - 1'b1;
         end
         if (load) begin
            b_in = fresh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.cnt <= '0;
         b_ff.cnt <= '0;
      end else begin
         a_ff.cnt <= a_in.cnt;
         b_ff.cnt <= b_in.cnt;
      end
      a_ff.data <= a_in.data;
      a_ff.eob  <= a_in.eob;
      b_ff.data <= b_in.data;
      b_ff.eob  <= b_in.eob;
   end

   assign rsp_tvalid = a_valid;
   assign rsp_tdata  = a_ff.data[BYTE_W-1:0];
   assign rsp_tlast  = (a_ff.cnt == CNT_W'(1));
   assign rsp_tuser  = a_ff.eob && (a_ff.cnt == CNT_W'(1));

endmodule

// ----- rtl/imaenc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imaenc_checker
// Port-level checks of the ADPCM block encoder, bound to the top level.
// ----------------------------------------------------------------------------
module imaenc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [imaenc_pkg::BYTE_W-1:0] rsp_tdata,
   input logic                          rsp_tlast,
   input logic                          rsp_tuser
);

   // nothing queued right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // no two frames are taken back to back
   a_frame_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted in two consecutive cycles");

   // a burst drains without gaps once started
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a result burst");

   // end of block only on the last byte of a burst
   a_eob_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("end of block without last byte");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind ima_adpcm_block_encoder imaenc_checker u_imaenc_checker (.*);
